// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants, types and state codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 2 * 1024 * 1024;
    localparam int HEADER_BYTES = 12;
    localparam int MAX_BLOCKS   = 64;
    localparam int SPLIT_SLACK  = 4;

    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int OFF_W  = 21;
    localparam int SIZE_W = 22;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_BAD_FREE   = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] bytes;
        logic             free;
    } entry_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_UP_RD,
        S_UP_WR,
        S_TAIL_WR,
        S_NXT_RD,
        S_NXT_CHK,
        S_PRV_RD,
        S_PRV_CHK,
        S_MRG_WR,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

endpackage

// ===== hdl/ffha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [ffha_pkg::SIZE_W-1:0] request_bytes;
    logic [ffha_pkg::OFF_W-1:0]  release_offset;

    modport source (output valid, action, request_bytes, release_offset, input ready);
    modport sink   (input valid, action, request_bytes, release_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ffha_pkg::OFF_W-1:0] payload_offset;
    logic [1:0]                 status;

    modport source (output valid, payload_offset, status, input ready);
    modport sink   (input valid, payload_offset, status, output ready);
endinterface

// ===== hdl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split on allocate and coalescing on free.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                  | Handshake
// req     | in  | action, request_bytes, release_offset    | valid/ready
// rsp     | out | payload_offset, status                   | valid/ready
//
// Steps: an item scans table entries in order, reading then checking each,
//   and when a split opens a slot or a merge closes one it moves the entries
//   behind that slot, reading then writing each. The scan and the move cover
//   disjoint parts of the table.
// Reset: after rst_n releases, the S_INIT state writes the initial free
//   block; req.ready stays low until that write is done.
// Stalls: the result sits in an output register; a new item is taken while
//   it waits, and a finished item holds only if that register is still full.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
(
    input  logic              clk,
    input  logic              rst_n,
    ffha_req_if.sink          req,
    ffha_rsp_if.source        rsp
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int OW = ffha_pkg::OFF_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam logic [OW-1:0] HDR = OW'(ffha_pkg::HEADER_BYTES);

    // Block table: address-ordered, single write port, registered read.
    ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
    ffha_pkg::entry_t rdata_reg;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    ffha_pkg::entry_t wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    ffha_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;     // entry under test / merge target
    logic [CW-1:0]     sh_reg, sh_next;       // shift cursor
    logic [1:0]        rm_reg, rm_next;       // entries to drop after a merge
    logic              act_reg, act_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [OW-1:0]     off_reg, off_next;
    ffha_pkg::entry_t  cur_reg, cur_next;
    logic [OW-1:0]     res_off_reg, res_off_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [OW-1:0]     out_off_reg, out_off_next;
    logic [1:0]        out_st_reg, out_st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_INIT;
            count_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sh_reg      <= sh_next;
        rm_reg      <= rm_next;
        act_reg     <= act_next;
        size_reg    <= size_next;
        off_reg     <= off_next;
        cur_reg     <= cur_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
    end

    assign req.ready          = (state_reg == ffha_pkg::S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.payload_offset = out_off_reg;
    assign rsp.status         = out_st_reg;

    logic [SW:0]   split_limit;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] sh_src;

    assign split_limit = {1'b0, size_reg} + (SW+1)'(ffha_pkg::HEADER_BYTES
                                                   + ffha_pkg::SPLIT_SLACK);
    assign idx_inc     = idx_reg + CW'(1);
    assign sh_src      = sh_reg + CW'(rm_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        sh_next        = sh_reg;
        rm_next        = rm_reg;
        act_next       = act_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        cur_next       = cur_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = cur_reg;
        raddr          = idx_reg[AW-1:0];

        // Drop the result once the sink takes it.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffha_pkg::S_INIT:
            begin
                // Seed the table with one free block over the whole heap.
                we         = 1'b1;
                waddr      = '0;
                wdata      = '{start: '0,
                               bytes: OW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES),
                               free: 1'b1};
                count_next = CW'(1);
                state_next = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next     = req.action;
                    size_next    = req.request_bytes;
                    off_next     = req.release_offset;
                    idx_next     = '0;
                    rm_next      = '0;
                    res_off_next = '0;
                    if (req.action == ffha_pkg::ACT_ALLOC)
                    begin
                        res_st_next = ffha_pkg::ST_ALLOC_FAIL;
                        state_next  = (req.request_bytes == '0) ? ffha_pkg::S_FINISH
                                                                 : ffha_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        // Freeing offset zero is a no-op.
                        res_st_next = (req.release_offset == '0) ? ffha_pkg::ST_OK
                                                                  : ffha_pkg::ST_BAD_FREE;
                        state_next  = (req.release_offset == '0) ? ffha_pkg::S_FINISH
                                                                  : ffha_pkg::S_SCAN_RD;
                    end
                end
            end
            ffha_pkg::S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ffha_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ffha_pkg::S_SCAN_CHK;
                end
            end
            ffha_pkg::S_SCAN_CHK:
            begin
                idx_next   = idx_inc;
                state_next = ffha_pkg::S_SCAN_RD;
                if (act_reg == ffha_pkg::ACT_ALLOC)
                begin
                    if (rdata_reg.free && ({1'b0, rdata_reg.bytes} >= size_reg))
                    begin
                        idx_next     = idx_reg;
                        cur_next     = rdata_reg;
                        res_off_next = rdata_reg.start + HDR;
                        res_st_next  = ffha_pkg::ST_OK;
                        we           = 1'b1;
                        wdata        = '{start: rdata_reg.start, bytes: rdata_reg.bytes,
                                         free: 1'b0};
                        if (({2'b0, rdata_reg.bytes} > split_limit)
                            && (count_reg < CW'(ffha_pkg::MAX_BLOCKS)))
                        begin
                            // Shrink the head now; open a slot for the tail.
                            wdata.bytes = size_reg[OW-1:0];
                            sh_next     = count_reg;
                            state_next  = ffha_pkg::S_UP_RD;
                        end
                        else
                        begin
                            state_next = ffha_pkg::S_FINISH;
                        end
                    end
                end
                else if ((rdata_reg.start + HDR) == off_reg)
                begin
                    idx_next      = idx_reg;
                    cur_next      = rdata_reg;
                    cur_next.free = 1'b1;
                    res_st_next   = ffha_pkg::ST_OK;
                    state_next    = ffha_pkg::S_NXT_RD;
                end
            end
            ffha_pkg::S_UP_RD:
            begin
                raddr = AW'(sh_reg - CW'(1));
                if (sh_reg == idx_inc)
                begin
                    state_next = ffha_pkg::S_TAIL_WR;
                end
                else
                begin
                    state_next = ffha_pkg::S_UP_WR;
                end
            end
            ffha_pkg::S_UP_WR:
            begin
                we         = 1'b1;
                waddr      = sh_reg[AW-1:0];
                wdata      = rdata_reg;
                sh_next    = sh_reg - CW'(1);
                state_next = ffha_pkg::S_UP_RD;
            end
            ffha_pkg::S_TAIL_WR:
            begin
                we         = 1'b1;
                waddr      = idx_inc[AW-1:0];
                wdata      = '{start: cur_reg.start + HDR + size_reg[OW-1:0],
                               bytes: cur_reg.bytes - size_reg[OW-1:0] - HDR,
                               free: 1'b1};
                count_next = count_reg + CW'(1);
                state_next = ffha_pkg::S_FINISH;
            end
            ffha_pkg::S_NXT_RD:
            begin
                raddr = idx_inc[AW-1:0];
                state_next = (idx_inc < count_reg) ? ffha_pkg::S_NXT_CHK
                                                   : ffha_pkg::S_PRV_RD;
            end
            ffha_pkg::S_NXT_CHK:
            begin
                if (rdata_reg.free)
                begin
                    cur_next.bytes = cur_reg.bytes + HDR + rdata_reg.bytes;
                    rm_next        = 2'd1;
                end
                state_next = ffha_pkg::S_PRV_RD;
            end
            ffha_pkg::S_PRV_RD:
            begin
                raddr = AW'(idx_reg - CW'(1));
                state_next = (idx_reg != '0) ? ffha_pkg::S_PRV_CHK
                                             : ffha_pkg::S_MRG_WR;
            end
            ffha_pkg::S_PRV_CHK:
            begin
                if (rdata_reg.free)
                begin
                    // Fold the freed block into its free predecessor.
                    cur_next = '{start: rdata_reg.start,
                                 bytes: rdata_reg.bytes + HDR + cur_reg.bytes,
                                 free: 1'b1};
                    idx_next = idx_reg - CW'(1);
                    rm_next  = rm_reg + 2'd1;
                end
                state_next = ffha_pkg::S_MRG_WR;
            end
            ffha_pkg::S_MRG_WR:
            begin
                we         = 1'b1;
                sh_next    = idx_inc;
                state_next = (rm_reg == '0) ? ffha_pkg::S_FINISH : ffha_pkg::S_DN_RD;
            end
            ffha_pkg::S_DN_RD:
            begin
                raddr = sh_src[AW-1:0];
                if (sh_src >= count_reg)
                begin
                    count_next = count_reg - CW'(rm_reg);
                    state_next = ffha_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ffha_pkg::S_DN_WR;
                end
            end
            ffha_pkg::S_DN_WR:
            begin
                we         = 1'b1;
                waddr      = sh_reg[AW-1:0];
                wdata      = rdata_reg;
                sh_next    = sh_reg + CW'(1);
                state_next = ffha_pkg::S_DN_RD;
            end
            ffha_pkg::S_FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    state_next     = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to first_fit_heap_allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [20:0] out_offset,
    input logic [1:0]  out_status
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_offset) && $stable(out_status), "result changed while stalled")
    `ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status <= ffha_pkg::ST_BAD_FREE, "undefined status code")
    `ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_status != ffha_pkg::ST_OK, out_offset == 21'd0, "failed item carries an offset")
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "took a second item while busy")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_offset (rsp.payload_offset),
    .out_status (rsp.status)
);
